@@ hw/rtl/pcs_pkg.sv @@
// Shared types and constants for the percentile contrast stretch block.
// Used by the channel interfaces, all RTL modules and the checker.
// No dependencies.
package pcs_pkg;

	// Pixel and histogram geometry.
	localparam int PIX_W = 8;
	localparam int NUM_BINS = 256;
	localparam int BIN_W = $clog2(NUM_BINS);
	localparam logic [PIX_W-1:0] LEVEL_MAX = 8'd255;

	// Frame pixel limit; the counters are wide enough to hold the limit itself.
	localparam longint unsigned MAX_PIXELS = 64'd16777216;
	localparam int CNT_W = $clog2(MAX_PIXELS + 1);

	// Clip fraction register and the cut product.
	localparam int CLIP_W = 16;
	localparam int CUT_PROD_W = CLIP_W + CNT_W;

	// Configuration port.
	localparam int DATA_W = 32;
	localparam int PADDR_W = 3;
	localparam int ADDR_LSB = 2;
	localparam int REG_IDX_W = PADDR_W - ADDR_LSB;
	localparam logic [REG_IDX_W-1:0] REG_CLIP = 1'b0;

	// Mapping arithmetic: q = floor(N * m / 2^RECIP_SHIFT), where
	// N = 510*v + d and m = ceil(2^RECIP_SHIFT / (2*d)).
	localparam int RECIP_SHIFT = 26;
	localparam int RECIP_W = 26;
	localparam int RECIP_SPLIT = 13;
	localparam logic [RECIP_W-1:0] RECIP_ONE = 26'h200_0000;
	localparam int DIV_CNT_W = $clog2(RECIP_W);
	localparam int NUM_W = 17;
	localparam logic [NUM_W-1:0] MAP_SCALE = 17'd510;
	localparam int PP_W = NUM_W + RECIP_SPLIT;
	localparam int PROD_W = NUM_W + RECIP_W;

	// Request actions.
	typedef enum logic [1:0] {
		ACT_START  = 2'd0,
		ACT_ACCUM  = 2'd1,
		ACT_FINISH = 2'd2,
		ACT_MAP    = 2'd3
	} action_t;

	// Result kinds.
	localparam logic KIND_MAP = 1'b0;
	localparam logic KIND_BOUNDS = 1'b1;

	// Histogram write port.
	typedef struct packed {
		logic             en;
		logic [BIN_W-1:0] addr;
		logic [CNT_W-1:0] data;
	} hist_wr_t;

	// Reciprocal unit response.
	typedef struct packed {
		logic               done;
		logic [RECIP_W-1:0] quot;
	} recip_rsp_t;

endpackage

@@ hw/rtl/pcs_in_if.sv @@
// Input request channel of the percentile contrast stretch block.
// Depends on pcs_pkg.
interface pcs_in_if import pcs_pkg::*; ();
	logic             valid;
	logic             ready;
	action_t          action;
	logic [PIX_W-1:0] pixel;

	modport source (output valid, output action, output pixel, input ready);
	modport sink (input valid, input action, input pixel, output ready);
endinterface

@@ hw/rtl/pcs_out_if.sv @@
// Result channel of the percentile contrast stretch block.
// Depends on pcs_pkg.
interface pcs_out_if import pcs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             report_kind;
	logic [PIX_W-1:0] mapped_pixel;
	logic [PIX_W-1:0] low_level;
	logic [PIX_W-1:0] high_level;
	logic             stretch_on;

	modport source (output valid, output report_kind, output mapped_pixel,
		output low_level, output high_level, output stretch_on, input ready);
	modport sink (input valid, input report_kind, input mapped_pixel,
		input low_level, input high_level, input stretch_on, output ready);
endinterface

@@ hw/rtl/pcs_hist_ram.sv @@
// Histogram store: 256 bin counters in a synchronous RAM with registered reads.
// Per-bin valid flops make cleared bins read as zero. Depends on pcs_pkg.
module pcs_hist_ram import pcs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clear,
	input  hist_wr_t         wr,
	input  logic [BIN_W-1:0] rd_addr,
	output logic [CNT_W-1:0] rd_data
);

	logic [CNT_W-1:0] mem [NUM_BINS];
	logic [NUM_BINS-1:0] vld_q;
	logic [CNT_W-1:0] rd_q;
	logic rd_vld_q;

	// Storage array with a registered read; read returns the old data on a collision.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_q <= mem[rd_addr];
		rd_vld_q <= vld_q[rd_addr];
	end

	// Valid bits; a clear wins over a write in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clear) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wr.addr] <= 1'b1;
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

@@ hw/rtl/pcs_recip_div.sv @@
// Reciprocal unit: m = ceil(2^25 / d) for 1 <= d <= 255, one quotient bit per cycle.
// Restoring division. Depends on pcs_pkg.
module pcs_recip_div import pcs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [PIX_W-1:0] divisor,
	output recip_rsp_t       rsp
);

	logic busy_q;
	logic done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [RECIP_W-1:0] num_q;
	logic [RECIP_W-1:0] quo_q;
	logic [PIX_W-1:0] rem_q;
	logic [PIX_W-1:0] div_q;
	logic [PIX_W:0] trial;
	logic fits;

	// One restoring step: bring down the next numerator bit and try the subtract.
	assign trial = {rem_q, num_q[RECIP_W-1]};
	assign fits = trial >= {1'b0, div_q};

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(RECIP_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath. The numerator 2^25 + d - 1 turns the floor into a ceiling.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= RECIP_ONE + RECIP_W'(divisor) - 1'b1;
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[RECIP_W-2:0], 1'b0};
			quo_q <= {quo_q[RECIP_W-2:0], fits};
			rem_q <= fits ? PIX_W'(trial - {1'b0, div_q}) : trial[PIX_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

@@ hw/rtl/percentile_contrast_stretch_top.sv @@
// Percentile contrast stretch for 8-bit gray pixels.
// Requests arrive on the pixels channel (action, pixel); results leave on the
// results channel. A start request clears the histogram and pixel count; an
// accumulate request counts one pixel, one per cycle back to back (the bin
// RAM does read-modify-write with forwarding); neither produces a result.
// A finish request walks the histogram from the top, then from the bottom,
// one bin per RAM read cycle. When the walks leave low below high, the
// reciprocal unit then takes 26 steps to form the reciprocal of the span
// before the bounds report is presented. A map request is accepted, then
// runs the split multiply, then rounds and clamps.
// The clip fraction is written through the APB-style port at byte address 0;
// the user must write it only while the block is idle, as the block itself
// does not enforce this.
// Reset clears the count and sets the bounds to 0 and 255 with stretching
// off; per-bin valid flops make the histogram read as zero at once, so no
// clearing pass is needed.
// Results sit in an output register. When the receiver stalls, start and
// accumulate requests are still taken; a map or finish request completes its
// work and then waits for that register to free up before taking the next.
module percentile_contrast_stretch_top import pcs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	pcs_in_if.sink             pixels,
	pcs_out_if.source          results
);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_CUT      = 9'b000000010,
		S_HI       = 9'b000000100,
		S_LO       = 9'b000001000,
		S_SETUP    = 9'b000010000,
		S_DIV      = 9'b000100000,
		S_REPORT   = 9'b001000000,
		S_MAP_MUL  = 9'b010000000,
		S_MAP_OUT  = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	logic [CLIP_W-1:0] clip_q;
	logic [CNT_W-1:0] total_q;
	logic [PIX_W-1:0] lo_q, hi_q;
	logic stretch_q;

	logic in_fire, clear, out_free;
	logic acc_s1;
	logic [BIN_W-1:0] acc_pix_s1;
	logic fwd_vld_q;
	logic [BIN_W-1:0] fwd_addr_q;
	logic [CNT_W-1:0] fwd_data_q;
	logic [CNT_W-1:0] bin_base;
	hist_wr_t hist_wr;
	logic [BIN_W-1:0] rd_addr;
	logic [CNT_W-1:0] rd_data;

	logic [CUT_PROD_W-1:0] cut_prod;
	logic [CNT_W-1:0] cut_q, sum_q;
	logic [CNT_W:0] sum_ext;
	logic fits;
	logic [BIN_W-1:0] ptr_q;
	logic iss_ok_q, iss_s1;
	logic walking;

	logic div_start;
	recip_rsp_t div_rsp;
	logic [RECIP_W-1:0] recip_q;

	logic [PIX_W-1:0] pix_q;
	logic [PIX_W-1:0] map_v, map_d;
	logic [NUM_W-1:0] map_num;
	logic [PP_W-1:0] pp_lo_s1, pp_hi_s1;
	logic map_pass_s1, map_zero_s1;
	logic [PROD_W-1:0] map_prod;
	logic [NUM_W-1:0] map_q;
	logic [PIX_W-1:0] map_res;

	logic out_valid_q, out_kind_q, out_stretch_q;
	logic [PIX_W-1:0] out_mapped_q, out_low_q, out_high_q;

	// Handshake decode.
	assign pixels.ready = (state_q == S_IDLE);
	assign in_fire = pixels.valid && pixels.ready;
	assign clear = in_fire && (pixels.action == ACT_START);
	assign out_free = !out_valid_q || results.ready;

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_W-1:ADDR_LSB] == REG_CLIP) ? DATA_W'(clip_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q <= '0;
		end else if (psel && penable && pwrite && pready &&
			paddr[PADDR_W-1:ADDR_LSB] == REG_CLIP) begin
			clip_q <= pwdata[CLIP_W-1:0];
		end
	end

	// Histogram update: the bin read in the accept cycle is incremented in the next
	// cycle; the last written bin is forwarded when the same bin comes right after.
	assign bin_base = (fwd_vld_q && fwd_addr_q == acc_pix_s1) ? fwd_data_q : rd_data;
	assign hist_wr.en = acc_s1;
	assign hist_wr.addr = acc_pix_s1;
	assign hist_wr.data = bin_base + 1'b1;

	assign walking = (state_q == S_HI) || (state_q == S_LO);
	assign rd_addr = walking ? ptr_q : pixels.pixel;

	pcs_hist_ram u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (clear),
		.wr      (hist_wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Bound walk compare and cut product.
	assign cut_prod = CUT_PROD_W'(clip_q) * CUT_PROD_W'(total_q);
	assign sum_ext = {1'b0, sum_q} + {1'b0, rd_data};
	assign fits = sum_ext <= {1'b0, cut_q};

	// Reciprocal of the bound span for mapping.
	assign div_start = (state_q == S_SETUP) && (lo_q < hi_q);

	pcs_recip_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (hi_q - lo_q),
		.rsp     (div_rsp)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire && pixels.action == ACT_FINISH) begin
					state_d = S_CUT;
				end else if (in_fire && pixels.action == ACT_MAP) begin
					state_d = S_MAP_MUL;
				end
			end
			S_CUT: state_d = S_HI;
			S_HI: begin
				if (iss_s1 && (!fits || hi_q == 8'd1)) begin
					state_d = S_LO;
				end
			end
			S_LO: begin
				if (iss_s1 && (!fits || lo_q == LEVEL_MAX - 1'b1)) begin
					state_d = S_SETUP;
				end
			end
			S_SETUP: state_d = (lo_q < hi_q) ? S_DIV : S_REPORT;
			S_DIV: begin
				if (div_rsp.done) begin
					state_d = S_REPORT;
				end
			end
			S_REPORT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_MAP_MUL: state_d = S_MAP_OUT;
			S_MAP_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers: state, count, forwarding, bounds and walk issue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= '0;
			acc_s1 <= 1'b0;
			fwd_vld_q <= 1'b0;
			lo_q <= '0;
			hi_q <= LEVEL_MAX;
			stretch_q <= 1'b0;
			iss_ok_q <= 1'b0;
			iss_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			fwd_vld_q <= acc_s1 && !clear;

			// Count the pixel at accept; full frames drop further pixels.
			acc_s1 <= 1'b0;
			if (clear) begin
				total_q <= '0;
			end else if (in_fire && pixels.action == ACT_ACCUM &&
				total_q < CNT_W'(MAX_PIXELS)) begin
				total_q <= total_q + 1'b1;
				acc_s1 <= 1'b1;
			end

			// Walk down from the top bound; one read issued per cycle.
			if (state_q == S_CUT) begin
				hi_q <= LEVEL_MAX;
				iss_ok_q <= 1'b1;
				iss_s1 <= 1'b0;
			end else if (state_q == S_HI) begin
				iss_s1 <= iss_ok_q;
				if (iss_ok_q) begin
					iss_ok_q <= (ptr_q != '0);
				end
				if (iss_s1 && fits) begin
					hi_q <= hi_q - 1'b1;
				end
				if (state_d == S_LO) begin
					lo_q <= '0;
					iss_ok_q <= 1'b1;
					iss_s1 <= 1'b0;
				end
			end else if (state_q == S_LO) begin
				// Walk up from the bottom bound.
				iss_s1 <= iss_ok_q;
				if (iss_ok_q) begin
					iss_ok_q <= (ptr_q != BIN_W'(NUM_BINS - 1));
				end
				if (iss_s1 && fits) begin
					lo_q <= lo_q + 1'b1;
				end
				if (state_d == S_SETUP) begin
					iss_ok_q <= 1'b0;
					iss_s1 <= 1'b0;
				end
			end

			if (state_q == S_SETUP) begin
				stretch_q <= (lo_q < hi_q);
			end
		end
	end

	// Walk datapath: cut, running sum and read pointer.
	always_ff @(posedge clk) begin
		if (state_q == S_CUT) begin
			cut_q <= cut_prod[CUT_PROD_W-1:CLIP_W];
			sum_q <= '0;
			ptr_q <= LEVEL_MAX - 1'b1;
		end else if (state_q == S_HI) begin
			if (iss_ok_q) begin
				ptr_q <= ptr_q - 1'b1;
			end
			if (iss_s1 && fits) begin
				sum_q <= sum_ext[CNT_W-1:0];
			end
			if (state_d == S_LO) begin
				sum_q <= '0;
				ptr_q <= BIN_W'(1);
			end
		end else if (state_q == S_LO) begin
			if (iss_ok_q) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (iss_s1 && fits) begin
				sum_q <= sum_ext[CNT_W-1:0];
			end
		end
	end

	// Accumulate pipeline payload, forwarding copy of the last write and reciprocal capture.
	always_ff @(posedge clk) begin
		acc_pix_s1 <= pixels.pixel;
		fwd_addr_q <= hist_wr.addr;
		fwd_data_q <= hist_wr.data;
		if (div_rsp.done) begin
			recip_q <= div_rsp.quot;
		end
	end

	// Map stage one: numerator 510*v + d times the reciprocal, in two halves.
	assign map_v = pix_q - lo_q;
	assign map_d = hi_q - lo_q;
	assign map_num = NUM_W'(map_v) * MAP_SCALE + NUM_W'(map_d);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pix_q <= pixels.pixel;
		end
		if (state_q == S_MAP_MUL) begin
			pp_lo_s1 <= PP_W'(map_num) * PP_W'(recip_q[RECIP_SPLIT-1:0]);
			pp_hi_s1 <= PP_W'(map_num) * PP_W'(recip_q[RECIP_W-1:RECIP_SPLIT]);
			map_pass_s1 <= !stretch_q;
			map_zero_s1 <= (pix_q <= lo_q);
		end
	end

	// Map stage two: recombine, take the quotient, clamp to full scale, or pass through or give zero.
	assign map_prod = {pp_hi_s1, RECIP_SPLIT'(0)} + PROD_W'(pp_lo_s1);
	assign map_q = map_prod[PROD_W-1:RECIP_SHIFT];

	always_comb begin
		if (map_pass_s1) begin
			map_res = pix_q;
		end else if (map_zero_s1) begin
			map_res = '0;
		end else if (map_q > NUM_W'(LEVEL_MAX)) begin
			map_res = LEVEL_MAX;
		end else begin
			map_res = map_q[PIX_W-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_REPORT || state_q == S_MAP_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_REPORT || state_q == S_MAP_OUT) && out_free) begin
			out_kind_q <= (state_q == S_REPORT) ? KIND_BOUNDS : KIND_MAP;
			out_mapped_q <= (state_q == S_REPORT) ? '0 : map_res;
			out_low_q <= lo_q;
			out_high_q <= hi_q;
			out_stretch_q <= stretch_q;
		end
	end

	assign results.valid = out_valid_q;
	assign results.report_kind = out_kind_q;
	assign results.mapped_pixel = out_mapped_q;
	assign results.low_level = out_low_q;
	assign results.high_level = out_high_q;
	assign results.stretch_on = out_stretch_q;

endmodule

@@ hw/rtl/pcs_checker.sv @@
// Port-level checks for the percentile contrast stretch block, bound to the top.
// Depends on pcs_pkg and percentile_contrast_stretch_top.
module pcs_checker import pcs_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic [1:0]       in_action,
	input logic             out_valid,
	input logic             out_ready,
	input logic             out_kind,
	input logic [PIX_W-1:0] out_mapped,
	input logic [PIX_W-1:0] out_low,
	input logic [PIX_W-1:0] out_high,
	input logic             out_stretch
);

	// A stalled result keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_mapped) &&
		$stable(out_low) && $stable(out_high) && $stable(out_kind))
		else $error("stalled result changed");

	// A bounds report carries no pixel.
	a_report_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_BOUNDS |-> out_mapped == '0)
		else $error("bounds report with nonzero pixel");

	// A bounds report enables stretching exactly when low is below high.
	a_report_stretch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_BOUNDS |-> out_stretch == (out_low < out_high))
		else $error("stretch flag disagrees with bounds");

	// Finish and map requests keep the block busy after they are accepted.
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_action == ACT_FINISH || in_action == ACT_MAP)
		|=> !in_ready)
		else $error("request taken while a finish or map is in progress");

endmodule

bind percentile_contrast_stretch_top pcs_checker u_pcs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (pixels.valid),
	.in_ready    (pixels.ready),
	.in_action   (pixels.action),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.out_kind    (results.report_kind),
	.out_mapped  (results.mapped_pixel),
	.out_low     (results.low_level),
	.out_high    (results.high_level),
	.out_stretch (results.stretch_on)
);

@@ verif/tb_percentile_contrast_stretch_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for percentile_contrast_stretch_top: frames of start, accumulate,
// finish and map requests with random gaps and result stalls, checked against a predictor.
// Depends on pcs_pkg, pcs_in_if, pcs_out_if and the block's RTL.
module tb_percentile_contrast_stretch_top;
	import pcs_pkg::*;

	// Register index with no register behind it; writes there must be ignored.
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 1'b1;
	localparam int SETTLE_CYCLES = 16;
	localparam int TAIL_CYCLES = 600;
	localparam int ITEMS_PER_PHASE = 170;

	// One result as it leaves the block.
	typedef struct packed {
		logic             kind;
		logic [PIX_W-1:0] mapped;
		logic [PIX_W-1:0] low;
		logic [PIX_W-1:0] high;
		logic             on;
	} report_t;

	// Histogram predictor with the queue of reports it expects.
	class stretch_tracker;
		bit [CLIP_W-1:0] clip_q16;
		bit [CNT_W-1:0] bin_count [NUM_BINS];
		longint unsigned pixel_count;
		bit [PIX_W-1:0] low_level;
		bit [PIX_W-1:0] high_level;
		bit stretch_on;
		report_t expected_reports[$];
		int failures;

		function new();
			clip_q16 = '0;
			foreach (bin_count[i]) bin_count[i] = '0;
			pixel_count = 0;
			low_level = '0;
			high_level = LEVEL_MAX;
			stretch_on = 1'b0;
			failures = 0;
		endfunction

		function void write_register(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
			if (idx == REG_CLIP)
				clip_q16 = data[CLIP_W-1:0];
		endfunction

		// Walk in from both ends while the clipped sum stays within the cut.
		function void find_levels();
			longint unsigned cut;
			longint unsigned sum;
			int lo;
			int hi;
			cut = (longint'(clip_q16) * pixel_count) >> 16;
			sum = 0;
			hi = NUM_BINS - 1;
			while (hi > 0 && sum + bin_count[hi-1] <= cut) begin
				hi--;
				sum += bin_count[hi];
			end
			sum = 0;
			lo = 0;
			while (lo < NUM_BINS - 1 && sum + bin_count[lo+1] <= cut) begin
				lo++;
				sum += bin_count[lo];
			end
			low_level = PIX_W'(lo);
			high_level = PIX_W'(hi);
			stretch_on = (lo < hi);
		endfunction

		// Rounded linear stretch from [low, high] to the full range.
		function bit [PIX_W-1:0] stretch_level(bit [PIX_W-1:0] pix);
			int d;
			int v;
			int q;
			if (!stretch_on || low_level >= high_level)
				return pix;
			if (pix <= low_level)
				return '0;
			d = high_level - low_level;
			v = pix - low_level;
			q = (510 * v + d) / (2 * d);
			return (q > 255) ? LEVEL_MAX : PIX_W'(q);
		endfunction

		function void take_request(action_t act, logic [PIX_W-1:0] pix);
			report_t rep;
			rep = '0;
			case (act)
				ACT_START: begin
					foreach (bin_count[i]) bin_count[i] = '0;
					pixel_count = 0;
					return;
				end
				ACT_ACCUM: begin
					if (pixel_count < MAX_PIXELS) begin
						bin_count[pix]++;
						pixel_count++;
					end
					return;
				end
				ACT_FINISH: begin
					find_levels();
					rep.kind = KIND_BOUNDS;
				end
				default: begin
					rep.kind = KIND_MAP;
					rep.mapped = stretch_level(pix);
				end
			endcase
			rep.low = low_level;
			rep.high = high_level;
			rep.on = stretch_on;
			expected_reports.push_back(rep);
		endfunction

		function void log_failure(string msg);
			failures++;
			if (failures <= 10)
				$display("%s", msg);
		endfunction

		function void check_report(report_t got);
			report_t want;
			if (expected_reports.size() == 0) begin
				log_failure($sformatf("unexpected result: kind=%0d pix=%0d low=%0d high=%0d on=%0d",
					got.kind, got.mapped, got.low, got.high, got.on));
				return;
			end
			want = expected_reports.pop_front();
			if (got.kind !== want.kind || got.mapped !== want.mapped || got.low !== want.low
					|| got.high !== want.high || got.on !== want.on)
				log_failure($sformatf({"result mismatch: expected kind=%0d pix=%0d low=%0d ",
					"high=%0d on=%0d, got kind=%0d pix=%0d low=%0d high=%0d on=%0d"},
					want.kind, want.mapped, want.low, want.high, want.on,
					got.kind, got.mapped, got.low, got.high, got.on));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	pcs_in_if pixels_ch ();
	pcs_out_if results_ch ();

	stretch_tracker tracker = new();
	int burst_left = 0;
	int items_sent = 0;

	percentile_contrast_stretch_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pixels  (pixels_ch.sink),
		.results (results_ch.source)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit.
	initial begin
		#12_000_000;
		$display("[percentile_contrast_stretch_top] ERROR");
		$finish;
	end

	// Receiver stalls follow their own mode pattern: open, random, long stalls, mostly open.
	initial begin
		int mode;
		int run;
		int k;
		results_ch.ready <= 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			run = $urandom_range(20, 200);
			for (k = 0; k < run; k++) begin
				@(posedge clk);
				case (mode)
					0: results_ch.ready <= 1'b1;
					1: results_ch.ready <= 1'($urandom_range(0, 1));
					2: results_ch.ready <= (k % 24 == 23);
					default: results_ch.ready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n && results_ch.valid && results_ch.ready)
			tracker.check_report({results_ch.report_kind, results_ch.mapped_pixel,
				results_ch.low_level, results_ch.high_level, results_ch.stretch_on});
	end

	// Sends one request, opening a gap of random length (possibly none) first when the current burst is used up.
	task automatic send_item(action_t act, logic [PIX_W-1:0] pix);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				pixels_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		pixels_ch.valid <= 1'b1;
		pixels_ch.action <= act;
		pixels_ch.pixel <= pix;
		@(posedge clk);
		while (!pixels_ch.ready) @(posedge clk);
		tracker.take_request(act, pix);
		items_sent++;
	endtask

	// Holds the sender until every expected result is back and the block has settled.
	task automatic drain_and_settle();
		pixels_ch.valid <= 1'b0;
		while (tracker.expected_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, {ADDR_LSB{1'b0}}};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		tracker.write_register(idx, data);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// Return to idle between transfers.
		@(posedge clk);
	endtask

	// Reads the clip fraction back and compares it with the value last written.
	task automatic apb_check_clip();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {REG_CLIP, {ADDR_LSB{1'b0}}};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== DATA_W'(tracker.clip_q16))
			tracker.log_failure($sformatf("clip readback: expected %0d, got %0d",
				tracker.clip_q16, prdata));
		psel <= 1'b0;
		penable <= 1'b0;
		// Return to idle between transfers.
		@(posedge clk);
	endtask

	// Drains the block, updates the clip fraction, reads it back, and also pokes the unused address with junk.
	task automatic set_clip(int value);
		drain_and_settle();
		apb_write(REG_CLIP, {16'($urandom()), 16'(value)});
		apb_check_clip();
		apb_write(REG_SPARE, $urandom());
	endtask

	function automatic logic [PIX_W-1:0] cluster_pixel(int base, int span);
		int v;
		v = base + $urandom_range(0, span);
		return PIX_W'((v > 255) ? 255 : v);
	endfunction

	// A pixel at or right next to a level, to hit the rounding and clamp edges.
	function automatic logic [PIX_W-1:0] near_level(int lvl);
		int v;
		v = lvl - 1 + $urandom_range(0, 2);
		if (v < 0)
			v = 0;
		return PIX_W'((v > 255) ? 255 : v);
	endfunction

	// One frame: mostly well formed, sometimes missing its start or its finish,
	// sometimes replaced by a run of arbitrary requests.
	task automatic run_frame();
		int base;
		int span;
		int n_accum;
		int n_map;
		int pick;
		int i;
		if ($urandom_range(0, 9) == 0) begin
			n_map = $urandom_range(1, 10);
			for (i = 0; i < n_map; i++)
				send_item(action_t'($urandom_range(0, 3)), PIX_W'($urandom()));
			return;
		end
		if ($urandom_range(0, 9) != 0)
			send_item(ACT_START, PIX_W'($urandom()));
		case ($urandom_range(0, 2))
			0: begin base = 0; span = 255; end
			1: begin base = $urandom_range(0, 255); span = $urandom_range(0, 40); end
			default: begin base = $urandom_range(0, 200); span = $urandom_range(20, 120); end
		endcase
		n_accum = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 60);
		for (i = 0; i < n_accum; i++)
			send_item(ACT_ACCUM, cluster_pixel(base, span));
		if ($urandom_range(0, 7) == 0)
			drain_and_settle();
		if ($urandom_range(0, 9) != 0)
			send_item(ACT_FINISH, PIX_W'($urandom()));
		n_map = $urandom_range(1, 40);
		for (i = 0; i < n_map; i++) begin
			pick = $urandom_range(0, 9);
			if (pick < 7)
				send_item(ACT_MAP, PIX_W'($urandom()));
			else if (pick < 9)
				send_item(ACT_MAP, near_level(tracker.low_level));
			else
				send_item(ACT_MAP, near_level(tracker.high_level));
		end
	endtask

	// Main sequence: reset, directed cases, then random phases at several clip settings.
	initial begin
		int clip_plan [6];
		int p;
		int phase_end;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		pixels_ch.valid <= 1'b0;
		pixels_ch.action <= ACT_START;
		pixels_ch.pixel <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Before any finish the reset levels apply and pixels pass through.
		send_item(ACT_MAP, 8'd0);
		send_item(ACT_MAP, 8'd255);
		set_clip(13107);

		// Small known histogram with both end bins filled.
		send_item(ACT_START, 8'd0);
		send_item(ACT_ACCUM, 8'd0);
		send_item(ACT_ACCUM, 8'd255);
		send_item(ACT_ACCUM, 8'd10);
		send_item(ACT_ACCUM, 8'd10);
		send_item(ACT_ACCUM, 8'd20);
		send_item(ACT_ACCUM, 8'd50);
		send_item(ACT_ACCUM, 8'd100);
		send_item(ACT_ACCUM, 8'd200);
		send_item(ACT_ACCUM, 8'd240);
		send_item(ACT_ACCUM, 8'd128);
		send_item(ACT_FINISH, 8'd0);
		send_item(ACT_MAP, 8'd0);
		send_item(ACT_MAP, 8'd255);
		send_item(ACT_MAP, 8'd128);
		send_item(ACT_MAP, tracker.low_level);
		send_item(ACT_MAP, tracker.high_level);

		// A repeated finish recomputes from the same histogram.
		send_item(ACT_FINISH, 8'd255);

		// Start keeps the levels; an empty histogram then turns stretching off.
		send_item(ACT_START, 8'd255);
		send_item(ACT_MAP, 8'd128);
		send_item(ACT_FINISH, 8'd0);
		send_item(ACT_MAP, 8'd77);
		send_item(ACT_ACCUM, 8'd77);
		send_item(ACT_FINISH, 8'd0);
		send_item(ACT_MAP, 8'd77);

		// Random phases, from no clipping to the largest fraction.
		clip_plan[0] = 0;
		clip_plan[1] = 65535;
		clip_plan[2] = 32768;
		clip_plan[3] = 1;
		clip_plan[4] = $urandom_range(0, 65535);
		clip_plan[5] = $urandom_range(0, 6553);
		for (p = 0; p < 6; p++) begin
			set_clip(clip_plan[p]);
			phase_end = items_sent + ITEMS_PER_PHASE;
			while (items_sent < phase_end)
				run_frame();
		end

		pixels_ch.valid <= 1'b0;
		while (tracker.expected_reports.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.failures == 0 && tracker.expected_reports.size() == 0)
			$display("[percentile_contrast_stretch_top] OK");
		else
			$display("[percentile_contrast_stretch_top] ERROR");
		$finish;
	end
endmodule
